@@ hdl/geib_pkg.sv @@
// shared types and codes for the graph edge index builder
// no dependencies
package geib_pkg;

  localparam int VID_W = 10;
  localparam int FLD_W = 11;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 40;

  // operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // table selects
  localparam logic [1:0] SEL_OUT_ORDER = 2'd0;
  localparam logic [1:0] SEL_OUT_START = 2'd1;
  localparam logic [1:0] SEL_IN_ORDER  = 2'd2;
  localparam logic [1:0] SEL_IN_START  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // datapath phases
  localparam logic [2:0] PH_NONE = 3'd0;
  localparam logic [2:0] PH_CLR  = 3'd1;
  localparam logic [2:0] PH_CNT  = 3'd2;
  localparam logic [2:0] PH_PFX  = 3'd3;
  localparam logic [2:0] PH_PLC  = 3'd4;
  localparam logic [2:0] PH_READ = 3'd5;

  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] step;
    logic [1:0] pass;   // 0 out secondary, 1 out primary, 2 in secondary, 3 in primary
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic resp;
  } ctl_stat_t;

endpackage

@@ hdl/geib_datapath.sv @@
// edge stores, counting-sort scratch and index table memories
// depends on geib_pkg
module geib_datapath import geib_pkg::*; #(
  parameter int MAX_EDGES    = 1024,
  parameter int MAX_VERTICES = 1024,
  parameter int EAW = $clog2(MAX_EDGES),
  parameter int CAW = $clog2(MAX_VERTICES + 1),
  parameter int CW  = $clog2(MAX_EDGES + 1),
  parameter int IW  = (CAW > EAW) ? CAW : EAW
) (
  input  logic             clk_i,
  input  dp_cmd_t          cmd_i,
  input  logic [IW-1:0]    idx_i,
  input  logic             edge_we_i,
  input  logic [EAW-1:0]   edge_addr_i,
  input  logic [VID_W-1:0] src_i,
  input  logic [VID_W-1:0] dst_i,
  input  logic [FLD_W-1:0] rd_idx_i,
  output logic [EAW-1:0]   out_ord_o,
  output logic [EAW-1:0]   in_ord_o,
  output logic [CW-1:0]    out_st_o,
  output logic [CW-1:0]    in_st_o
);

  logic [VID_W-1:0] src_mem [MAX_EDGES];
  logic [VID_W-1:0] dst_mem [MAX_EDGES];
  logic [EAW-1:0]   scr_mem [MAX_EDGES];
  logic [EAW-1:0]   out_ord_mem [MAX_EDGES];
  logic [EAW-1:0]   in_ord_mem [MAX_EDGES];
  logic [CW-1:0]    cnt_mem [MAX_VERTICES + 1];
  logic [CW-1:0]    out_st_mem [MAX_VERTICES + 1];
  logic [CW-1:0]    in_st_mem [MAX_VERTICES + 1];

  logic [VID_W-1:0] src_rd_q, dst_rd_q;
  logic [EAW-1:0]   scr_rd_q, k_q;
  logic [CW-1:0]    cnt_rd_q, acc_q;
  logic [EAW-1:0]   out_ord_q, in_ord_q;
  logic [CW-1:0]    out_st_q, in_st_q;

  logic             primary, key_src;
  logic [VID_W-1:0] key;
  logic [CAW-1:0]   key_a, v_a;
  logic [EAW-1:0]   i_e, k_now;
  logic             key_re, cnt_re, cnt_we, ord_we, st_we, scr_re;
  logic [EAW-1:0]   key_addr;
  logic [CAW-1:0]   cnt_raddr, cnt_waddr;
  logic [CW-1:0]    cnt_wdata;
  logic [EAW-1:0]   ord_addr;

  always_comb begin
    primary   = cmd_i.pass[0];
    key_src   = (cmd_i.pass == 2'd1) || (cmd_i.pass == 2'd2);
    key       = key_src ? src_rd_q : dst_rd_q;
    key_a     = CAW'(key);
    v_a       = CAW'(idx_i);
    i_e       = EAW'(idx_i);
    k_now     = primary ? scr_rd_q : i_e;
    key_re    = 1'b0;
    key_addr  = i_e;
    scr_re    = 1'b0;
    cnt_re    = 1'b0;
    cnt_raddr = key_a;
    cnt_we    = 1'b0;
    cnt_waddr = key_a;
    cnt_wdata = cnt_rd_q + CW'(1);
    ord_we    = 1'b0;
    st_we     = 1'b0;
    ord_addr  = EAW'(cnt_rd_q);
    unique case (cmd_i.phase)
      PH_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = v_a;
        cnt_wdata = '0;
      end
      PH_CNT: begin
        key_re = (cmd_i.step == 2'd0);
        cnt_re = (cmd_i.step == 2'd1);
        cnt_we = (cmd_i.step == 2'd2);
      end
      PH_PFX: begin
        cnt_re    = (cmd_i.step == 2'd0);
        cnt_raddr = v_a;
        cnt_we    = (cmd_i.step == 2'd1);
        cnt_waddr = v_a;
        cnt_wdata = acc_q;
        st_we     = (cmd_i.step == 2'd1) && primary;
      end
      PH_PLC: begin
        scr_re   = (cmd_i.step == 2'd0);
        key_re   = (cmd_i.step == 2'd1);
        key_addr = k_now;
        cnt_re   = (cmd_i.step == 2'd2);
        cnt_we   = (cmd_i.step == 2'd3);
        ord_we   = (cmd_i.step == 2'd3);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (edge_we_i) begin
      src_mem[edge_addr_i] <= src_i;
      dst_mem[edge_addr_i] <= dst_i;
    end
    if (key_re) begin
      src_rd_q <= src_mem[key_addr];
      dst_rd_q <= dst_mem[key_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cnt_re) cnt_rd_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ord_we && !primary) scr_mem[ord_addr] <= k_q;
    if (scr_re) scr_rd_q <= scr_mem[i_e];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.phase == PH_PLC && cmd_i.step == 2'd1) k_q <= k_now;
    if (cmd_i.phase == PH_CLR) acc_q <= '0;
    else if (cmd_i.phase == PH_PFX && cmd_i.step == 2'd1) acc_q <= acc_q + cnt_rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (ord_we && cmd_i.pass == 2'd1) out_ord_mem[ord_addr] <= k_q;
    if (cmd_i.phase == PH_READ) out_ord_q <= out_ord_mem[EAW'(rd_idx_i)];
  end

  always_ff @(posedge clk_i) begin
    if (ord_we && cmd_i.pass == 2'd3) in_ord_mem[ord_addr] <= k_q;
    if (cmd_i.phase == PH_READ) in_ord_q <= in_ord_mem[EAW'(rd_idx_i)];
  end

  // exclusive prefix doubles as the start offset
  always_ff @(posedge clk_i) begin
    if (st_we && cmd_i.pass == 2'd1) out_st_mem[v_a] <= acc_q;
    if (cmd_i.phase == PH_READ) out_st_q <= out_st_mem[CAW'(rd_idx_i)];
  end

  always_ff @(posedge clk_i) begin
    if (st_we && cmd_i.pass == 2'd3) in_st_mem[v_a] <= acc_q;
    if (cmd_i.phase == PH_READ) in_st_q <= in_st_mem[CAW'(rd_idx_i)];
  end

  assign out_ord_o = out_ord_q;
  assign in_ord_o  = in_ord_q;
  assign out_st_o  = out_st_q;
  assign in_st_o   = in_st_q;

endmodule

@@ hdl/geib_ctrl.sv @@
// build and read sequencer driving the datapath phases
// depends on geib_pkg
module geib_ctrl import geib_pkg::*; #(
  parameter int MAX_EDGES    = 1024,
  parameter int MAX_VERTICES = 1024,
  parameter int EAW = $clog2(MAX_EDGES),
  parameter int CAW = $clog2(MAX_VERTICES + 1),
  parameter int CW  = $clog2(MAX_EDGES + 1),
  parameter int IW  = (CAW > EAW) ? CAW : EAW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          build_i,
  input  logic [CW-1:0] edge_cnt_i,
  input  logic          out_free_i,
  output dp_cmd_t       cmd_o,
  output logic [IW-1:0] idx_o,
  output ctl_stat_t     stat_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_CNT  = 3'd2;
  localparam logic [2:0] S_PFX  = 3'd3;
  localparam logic [2:0] S_PLC  = 3'd4;
  localparam logic [2:0] S_READ = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;

  localparam logic [IW-1:0] LAST_V = IW'(MAX_VERTICES);

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [1:0]    step_q, step_d, pass_q, pass_d;
  logic          last_e, no_edges;

  assign last_e   = (CW'(idx_q) == edge_cnt_i - CW'(1));
  assign no_edges = (edge_cnt_i == '0);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    step_d  = step_q;
    pass_d  = pass_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = build_i ? S_CLR : S_READ;
          idx_d   = '0;
          step_d  = '0;
          pass_d  = '0;
        end
      end
      S_CLR: begin
        if (idx_q == LAST_V) begin
          idx_d   = '0;
          state_d = no_edges ? S_PFX : S_CNT;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      S_CNT: begin
        step_d = step_q + 2'd1;
        if (step_q == 2'd2) begin
          step_d = '0;
          if (last_e) begin
            idx_d   = '0;
            state_d = S_PFX;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end
      S_PFX: begin
        step_d = step_q + 2'd1;
        if (step_q == 2'd1) begin
          step_d = '0;
          if (idx_q == LAST_V) begin
            idx_d = '0;
            if (!no_edges) state_d = S_PLC;
            else if (pass_q == 2'd3) state_d = S_READ;
            else begin
              pass_d  = pass_q + 2'd1;
              state_d = S_CLR;
            end
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end
      S_PLC: begin
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          step_d = '0;
          if (last_e) begin
            idx_d = '0;
            if (pass_q == 2'd3) state_d = S_READ;
            else begin
              pass_d  = pass_q + 2'd1;
              state_d = S_CLR;
            end
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end
      S_READ: state_d = S_RESP;
      S_RESP: if (out_free_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      step_q  <= '0;
      pass_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
      pass_q  <= pass_d;
    end
  end

  always_comb begin
    cmd_o.step = step_q;
    cmd_o.pass = pass_q;
    unique case (state_q)
      S_CLR:   cmd_o.phase = PH_CLR;
      S_CNT:   cmd_o.phase = PH_CNT;
      S_PFX:   cmd_o.phase = PH_PFX;
      S_PLC:   cmd_o.phase = PH_PLC;
      S_READ:  cmd_o.phase = PH_READ;
      default: cmd_o.phase = PH_NONE;
    endcase
  end

  assign idx_o       = idx_q;
  assign stat_o.busy = (state_q != S_IDLE);
  assign stat_o.resp = (state_q == S_RESP) && out_free_i;

endmodule

@@ hdl/graph_edge_index_builder_core.sv @@
// edge store with compressed sparse row tables built by counting sort on demand
// clear, append and other codes answer in the cycle after acceptance
// a read with current tables passes through the read and response states; after a change it first rebuilds,
// in four passes of clear, count, prefix and place (count and place skipped with no edges)
// throughput: one item a cycle for appends while the output is not stalled; reset clears counts and flags only
module graph_edge_index_builder_core import geib_pkg::*; #(
  parameter int MAX_EDGES    = 1024,
  parameter int MAX_VERTICES = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // operation, source_vertex, dest_vertex, table_select, entry_index
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // entry_value, status, vertex_count, edge_count
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int EAW = $clog2(MAX_EDGES);
  localparam int CAW = $clog2(MAX_VERTICES + 1);
  localparam int CW  = $clog2(MAX_EDGES + 1);
  localparam int IW  = (CAW > EAW) ? CAW : EAW;

  logic [1:0]       op, sel;
  logic [VID_W-1:0] src, dst;
  logic [FLD_W-1:0] idx;

  assign op  = s_axis_tdata[1:0];
  assign src = s_axis_tdata[11:2];
  assign dst = s_axis_tdata[21:12];
  assign sel = s_axis_tdata[23:22];
  assign idx = s_axis_tdata[34:24];

  logic [CW-1:0]    edges_q, edges_d;
  logic [VID_W-1:0] max_q, max_d;
  logic             cur_q, cur_d;
  logic [1:0]       sel_q, rstat_q;
  logic [FLD_W-1:0] ridx_q;
  logic             mv_q;
  logic [OUT_TDATA_W-1:0] md_q;

  ctl_stat_t        stat;
  dp_cmd_t          cmd;
  logic [IW-1:0]    cidx;
  logic [EAW-1:0]   out_ord, in_ord;
  logic [CW-1:0]    out_st, in_st;

  logic             out_free, accept, edge_we, start;
  logic [1:0]       imm_status, rd_status;
  logic [FLD_W-1:0] vc_cur, vc_next, rd_value;

  assign out_free      = !mv_q || m_axis_tready;
  assign s_axis_tready = !stat.busy && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign vc_cur  = (edges_q == '0) ? FLD_W'(1) : FLD_W'(max_q) + FLD_W'(1);
  assign vc_next = (edges_d == '0) ? FLD_W'(1) : FLD_W'(max_d) + FLD_W'(1);

  always_comb begin
    edges_d    = edges_q;
    max_d      = max_q;
    cur_d      = cur_q;
    edge_we    = 1'b0;
    start      = 1'b0;
    imm_status = ST_OK;
    if (accept) begin
      unique case (op)
        OP_CLEAR: begin
          edges_d = '0;
          max_d   = '0;
          cur_d   = 1'b0;
        end
        OP_APPEND: begin
          if (32'(edges_q) >= MAX_EDGES) imm_status = ST_FULL;
          else if (32'(src) >= MAX_VERTICES || 32'(dst) >= MAX_VERTICES) imm_status = ST_RANGE;
          else begin
            edge_we = 1'b1;
            edges_d = edges_q + CW'(1);
            if (src > max_d) max_d = src;
            if (dst > max_d) max_d = dst;
            cur_d = 1'b0;
          end
        end
        OP_READ: begin
          start = 1'b1;
          cur_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // range check made at acceptance, store does not change during the read
  always_comb begin
    if (sel == SEL_OUT_ORDER || sel == SEL_IN_ORDER)
      rd_status = (32'(idx) < 32'(edges_q)) ? ST_OK : ST_RANGE;
    else
      rd_status = (idx <= vc_cur) ? ST_OK : ST_RANGE;
  end

  always_comb begin
    unique case (sel_q)
      SEL_OUT_ORDER: rd_value = FLD_W'(out_ord);
      SEL_OUT_START: rd_value = FLD_W'(out_st);
      SEL_IN_ORDER:  rd_value = FLD_W'(in_ord);
      default:       rd_value = FLD_W'(in_st);
    endcase
    if (rstat_q != ST_OK) rd_value = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edges_q <= '0;
      max_q   <= '0;
      cur_q   <= 1'b0;
      mv_q    <= 1'b0;
    end else begin
      edges_q <= edges_d;
      max_q   <= max_d;
      cur_q   <= cur_d;
      if (stat.resp) mv_q <= 1'b1;
      else if (accept && op != OP_READ) mv_q <= 1'b1;
      else if (m_axis_tready) mv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && op == OP_READ) begin
      sel_q   <= sel;
      ridx_q  <= idx;
      rstat_q <= rd_status;
    end
    if (stat.resp)
      md_q <= {5'd0, FLD_W'(edges_q), vc_cur, rstat_q, rd_value};
    else if (accept && op != OP_READ)
      md_q <= {5'd0, FLD_W'(edges_d), vc_next, imm_status, FLD_W'(0)};
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = md_q;

  geib_ctrl #(
    .MAX_EDGES   (MAX_EDGES),
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .build_i   (!cur_q),
    .edge_cnt_i(edges_q),
    .out_free_i(out_free),
    .cmd_o     (cmd),
    .idx_o     (cidx),
    .stat_o    (stat)
  );

  geib_datapath #(
    .MAX_EDGES   (MAX_EDGES),
    .MAX_VERTICES(MAX_VERTICES)
  ) u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .idx_i      (cidx),
    .edge_we_i  (edge_we),
    .edge_addr_i(EAW'(edges_q)),
    .src_i      (src),
    .dst_i      (dst),
    .rd_idx_i   (ridx_q),
    .out_ord_o  (out_ord),
    .in_ord_o   (in_ord),
    .out_st_o   (out_st),
    .in_st_o    (in_st)
  );

endmodule

@@ hdl/geib_checker.sv @@
// port-level checks for the graph edge index builder, bound to the top level
// depends on geib_pkg
module geib_checker import geib_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[12:11] != 2'd3)
    else $error("undefined status code");

  a_vcount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:13] != 11'd0)
    else $error("vertex count is zero");

  // a clear answers next cycle with an empty store
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == OP_CLEAR
    |=> m_axis_tvalid && m_axis_tdata[34:24] == 11'd0 && m_axis_tdata[23:13] == 11'd1)
    else $error("clear not answered with empty store");

endmodule

bind graph_edge_index_builder_core geib_checker u_geib_checker (.*);
